[rtl/ffph_pkg.sv]
// ----------------------------------------------------------------------------
// ffph_pkg
// Shared types and constants of the first-fit page heap allocator.
// ----------------------------------------------------------------------------
package ffph_pkg;

    // default geometry
    localparam int unsigned PageBytesDef   = 4096;
    localparam int unsigned NumPagesDef    = 16;
    localparam int unsigned HeaderBytesDef = 8;

    // heap spans a 16-bit byte offset range
    localparam int unsigned Span   = 65536;
    // chunk sizes never exceed one page, at most Span bytes
    localparam int unsigned SizeW  = 17;
    // walk position: position plus chunk size
    localparam int unsigned PosW   = 18;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADADDR = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_TOOBIG  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] request_size;
        logic [15:0] address;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] value;
    } t_out_word;

    // one chunk header slot
    typedef struct packed {
        logic [SizeW-1:0] size;
        logic             used;
    } t_hdr;

    // header store access, addresses are heap byte offsets
    typedef struct packed {
        logic        we;
        logic [15:0] waddr;
        t_hdr        wdata;
        logic [15:0] raddr;
    } t_mem_req;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_NEXT,
        S_PAGE,
        S_MRD,
        S_MEV,
        S_FST,
        S_FRD,
        S_FEV,
        S_SPLIT,
        S_OPEN,
        S_OPEN2,
        S_FIND,
        S_QRD,
        S_QEV,
        S_DONE
    } t_state;

endpackage

[rtl/ffph_mem.sv]
// ----------------------------------------------------------------------------
// ffph_mem
// Header store: one write and one registered read per cycle, indexed by
// heap byte offset at the chunk alignment grain.
// ----------------------------------------------------------------------------
module ffph_mem #(
    parameter int unsigned GRAN_LG = 3
) (
    input  logic              i_clk,
    input  ffph_pkg::t_mem_req i_req,
    output ffph_pkg::t_hdr    o_rdata
);
    import ffph_pkg::*;

    localparam int unsigned Depth = Span >> GRAN_LG;

    t_hdr r_mem [Depth];
    t_hdr r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[15:GRAN_LG]] <= i_req.wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_req.raddr[15:GRAN_LG]];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/first_fit_page_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_page_heap_allocator
// Page heap with in-band chunk headers: first-fit allocate with merging of
// free runs, release and body size query, one word at a time.
// ----------------------------------------------------------------------------
// Sequence: release and query step through the pages before the addressed one,
//   then read its header; allocate visits each open page, reading every chunk
//   header twice (once to merge, once to fit), then finishes or opens a page.
// Throughput: one word at a time, at a rate set by the header walk.
// Reset: clears control state, then sweeps the header store to zero, one
//   slot per cycle, before taking words.
module first_fit_page_heap_allocator #(
    parameter int unsigned PAGE_BYTES   = ffph_pkg::PageBytesDef,
    parameter int unsigned NUM_PAGES    = ffph_pkg::NumPagesDef,
    parameter int unsigned HEADER_BYTES = ffph_pkg::HeaderBytesDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ffph_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ffph_pkg::t_out_word o_out_data
);
    import ffph_pkg::*;

    localparam int unsigned GranLg = (HEADER_BYTES % 8 == 0) ? 3 :
                                     (HEADER_BYTES % 4 == 0) ? 2 :
                                     (HEADER_BYTES % 2 == 0) ? 1 : 0;
    localparam int unsigned IdxW   = 16 - GranLg;
    localparam int unsigned Limit  = (NUM_PAGES < Span / PAGE_BYTES) ?
                                     NUM_PAGES : Span / PAGE_BYTES;
    localparam int unsigned PgW    = $clog2(Limit + 1);
    localparam logic [PosW-1:0] Pb     = PosW'(PAGE_BYTES);
    localparam logic [PosW-1:0] Hb     = PosW'(HEADER_BYTES);
    localparam logic [PosW-1:0] TooBig = PosW'(PAGE_BYTES - 2 * HEADER_BYTES);
    localparam logic [PgW-1:0]  LimitV = PgW'(Limit);

    t_state           r_state, n_state;
    logic [IdxW-1:0]  r_clr, n_clr;
    logic [1:0]       r_op, n_op;
    logic [15:0]      r_addr, n_addr;
    logic [PosW-1:0]  r_need, n_need;
    logic [PosW-1:0]  r_pos, n_pos;
    logic [PosW-1:0]  r_base, n_base;
    logic [PgW-1:0]   r_page, n_page;
    logic [PgW-1:0]   r_pages_open, n_pages_open;
    logic             r_have, n_have;
    logic [PosW-1:0]  r_last, n_last;
    logic [SizeW-1:0] r_last_size, n_last_size;
    logic             r_last_used, n_last_used;
    t_out_word        r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out, n_out;

    t_mem_req         mem_req;
    t_hdr             rdata;

    ffph_mem #(.GRAN_LG(GranLg)) u_mem (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rdata(rdata)
    );

    // shared decode of the header just read
    logic [PosW-1:0] rd_size, pos_adv, page_end, rounded, slot;
    logic            walk_end, fit, in_acc, out_free, slot_odd;

    assign rd_size  = PosW'(rdata.size);
    assign pos_adv  = r_pos + rd_size;
    assign page_end = r_base + Pb;
    assign walk_end = (rd_size == '0) || (pos_adv >= page_end);
    assign fit      = !rdata.used && (rd_size >= r_need);
    assign rounded  = (PosW'(i_in_data.request_size) + PosW'(7)) & ~PosW'(7);
    assign slot     = PosW'(r_addr) - Hb;
    assign slot_odd = (GranLg != 0) && ((slot & PosW'((1 << GranLg) - 1)) != '0);
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == '1) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.operation)
                        OP_ALLOC: n_state = (rounded >= TooBig) ? S_DONE : S_NEXT;
                        OP_FREE, OP_QUERY: n_state = S_FIND;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_NEXT: begin
                if (r_page < r_pages_open)      n_state = S_PAGE;
                else if (r_pages_open < LimitV) n_state = S_OPEN;
                else                            n_state = S_DONE;
            end
            S_PAGE:  n_state = S_MRD;
            S_MRD:   n_state = S_MEV;
            S_MEV:   n_state = walk_end ? S_FST : S_MRD;
            S_FST:   n_state = S_FRD;
            S_FRD:   n_state = S_FEV;
            S_FEV: begin
                if (rd_size == '0)   n_state = S_NEXT;
                else if (fit)        n_state = (rd_size != r_need) ? S_SPLIT : S_DONE;
                else if (walk_end)   n_state = S_NEXT;
                else                 n_state = S_FRD;
            end
            S_SPLIT: n_state = S_DONE;
            S_OPEN:  n_state = S_OPEN2;
            S_OPEN2: n_state = S_DONE;
            S_FIND: begin
                if (r_page >= r_pages_open)             n_state = S_DONE;
                else if (PosW'(r_addr) < page_end) begin
                    if ((PosW'(r_addr) - r_base) < Hb || slot_odd) n_state = S_DONE;
                    else                                          n_state = S_QRD;
                end
            end
            S_QRD:   n_state = S_QEV;
            S_QEV:   n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and header store access
    always_comb begin
        n_clr        = r_clr;
        n_op         = r_op;
        n_addr       = r_addr;
        n_need       = r_need;
        n_pos        = r_pos;
        n_base       = r_base;
        n_page       = r_page;
        n_pages_open = r_pages_open;
        n_have       = r_have;
        n_last       = r_last;
        n_last_size  = r_last_size;
        n_last_used  = r_last_used;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        mem_req      = '0;
        mem_req.raddr = r_pos[15:0];

        // output register drains independently
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = 16'(PosW'(r_clr) << GranLg);
                n_clr         = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op   = i_in_data.operation;
                    n_addr = i_in_data.address;
                    n_need = rounded + Hb;
                    n_page = '0;
                    n_base = '0;
                    n_res  = '0;
                    if (i_in_data.operation == OP_ALLOC && rounded >= TooBig) begin
                        n_res.status = ST_TOOBIG;
                    end
                end
            end
            S_NEXT: begin
                if (!(r_page < r_pages_open) && !(r_pages_open < LimitV)) begin
                    n_res.status = ST_NOSPACE;
                end
            end
            S_PAGE: begin
                n_pos  = r_base;
                n_have = 1'b0;
            end
            // merge runs of free chunks into the first of each run
            S_MEV: begin
                if (rd_size != '0) begin
                    if (!r_have || r_last_used || rdata.used) begin
                        n_have      = 1'b1;
                        n_last      = r_pos;
                        n_last_size = rdata.size;
                        n_last_used = rdata.used;
                    end else begin
                        n_last_size        = r_last_size + rdata.size;
                        mem_req.we         = 1'b1;
                        mem_req.waddr      = r_last[15:0];
                        mem_req.wdata.size = r_last_size + rdata.size;
                        mem_req.wdata.used = 1'b0;
                    end
                    n_pos = pos_adv;
                end
            end
            S_FST: n_pos = r_base;
            // first fit
            S_FEV: begin
                if (rd_size != '0 && fit) begin
                    mem_req.we         = 1'b1;
                    mem_req.waddr      = r_pos[15:0];
                    mem_req.wdata.size = r_need[SizeW-1:0];
                    mem_req.wdata.used = 1'b1;
                    n_last_size        = SizeW'(rd_size - r_need);
                    n_res.value        = 16'(r_pos + Hb);
                end else if (rd_size == '0 || walk_end) begin
                    n_page = r_page + 1'b1;
                    n_base = r_base + Pb;
                end else begin
                    n_pos = pos_adv;
                end
            end
            S_SPLIT: begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = 16'(r_pos + r_need);
                mem_req.wdata.size = r_last_size;
                mem_req.wdata.used = 1'b0;
            end
            // open a fresh page
            S_OPEN: begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = r_base[15:0];
                mem_req.wdata.size = r_need[SizeW-1:0];
                mem_req.wdata.used = 1'b1;
                n_res.value        = 16'(r_base + Hb);
            end
            S_OPEN2: begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = 16'(r_base + r_need);
                mem_req.wdata.size = SizeW'(Pb - r_need);
                mem_req.wdata.used = 1'b0;
                n_pages_open       = r_pages_open + 1'b1;
            end
            // locate page of a release or query address
            S_FIND: begin
                if (r_page >= r_pages_open) begin
                    n_res.status = ST_BADADDR;
                end else if (PosW'(r_addr) < page_end) begin
                    if ((PosW'(r_addr) - r_base) < Hb) n_res.status = ST_BADADDR;
                    n_pos = slot;
                end else begin
                    n_page = r_page + 1'b1;
                    n_base = r_base + Pb;
                end
            end
            S_QEV: begin
                if (r_op == OP_FREE) begin
                    mem_req.we         = 1'b1;
                    mem_req.waddr      = r_pos[15:0];
                    mem_req.wdata.size = rdata.size;
                    mem_req.wdata.used = 1'b0;
                end else begin
                    n_res.value = (rd_size >= Hb) ? 16'(rd_size - Hb) : 16'd0;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_pages_open <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_pages_open <= n_pages_open;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_addr      <= n_addr;
        r_need      <= n_need;
        r_pos       <= n_pos;
        r_base      <= n_base;
        r_page      <= n_page;
        r_have      <= n_have;
        r_last      <= n_last;
        r_last_size <= n_last_size;
        r_last_used <= n_last_used;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    // page count stays within the limit
    a_pages_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pages_open <= LimitV)
        else $error("open page count beyond limit");

    // pages open one at a time
    a_pages_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pages_open != $past(r_pages_open)) |-> (r_pages_open == $past(r_pages_open) + 1'b1))
        else $error("page count jumped");

    // no word taken during the clearing sweep
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("input taken while clearing");

    // header store is not written while idle
    a_idle_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_req.we)
        else $error("header write while idle");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench of the first-fit page heap allocator: directed and random
// allocate, release and size query words, checked against a built-in
// model of the paged heap, under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffph_pkg::*;

    localparam int unsigned PB        = PageBytesDef;
    localparam int unsigned HB        = HeaderBytesDef;
    localparam int unsigned PageMax   = (NumPagesDef < Span / PB) ? NumPagesDef : Span / PB;
    localparam longint      CycleMax  = 64'd400_000_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;

    first_fit_page_heap_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // heap model: bit 0 used, upper bits chunk size, one slot per byte offset
    int unsigned heap_hdr [Span];
    int unsigned pages_open_mdl = 0;
    t_out_word   expected_words[$];
    int unsigned live_bodies[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    longint      cycle_count = 0;

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned hdr_size(int unsigned pos);
        return heap_hdr[pos & (Span - 1)] >> 1;
    endfunction

    function automatic bit hdr_used(int unsigned pos);
        return heap_hdr[pos & (Span - 1)][0];
    endfunction

    function automatic void hdr_set(int unsigned pos, int unsigned size, bit used);
        heap_hdr[pos & (Span - 1)] = (size << 1) | used;
    endfunction

    // fold each run of free chunks into its first chunk
    function automatic void merge_page(int unsigned base);
        int unsigned pos;
        int unsigned last;
        int unsigned s;
        bit have;
        pos = base;
        last = base;
        have = 1'b0;
        while (pos < base + PB) begin
            s = hdr_size(pos);
            if (s == 0) break;
            if (!have) begin
                last = pos;
                have = 1'b1;
            end else if (!hdr_used(last) && !hdr_used(pos)) begin
                hdr_set(last, hdr_size(last) + s, 1'b0);
            end else begin
                last = pos;
            end
            pos += s;
        end
    endfunction

    // take the first free chunk that fits, split off the rest
    function automatic bit fit_page(int unsigned base, int unsigned need,
                                    output int unsigned body);
        int unsigned pos;
        int unsigned s;
        pos = base;
        body = 0;
        while (pos < base + PB) begin
            s = hdr_size(pos);
            if (s == 0) break;
            if (!hdr_used(pos) && s >= need) begin
                hdr_set(pos, need, 1'b1);
                if (s != need) hdr_set(pos + need, s - need, 1'b0);
                body = pos + HB;
                return 1'b1;
            end
            pos += s;
        end
        return 1'b0;
    endfunction

    function automatic t_out_word predict_heap(t_in_word w);
        t_out_word r;
        int unsigned size;
        int unsigned need;
        int unsigned body;
        int unsigned pg;
        int unsigned off;
        int unsigned s;
        bit done;
        r = '0;
        r.status = ST_OK;
        case (t_op'(w.operation))
            OP_ALLOC: begin
                size = (int'(w.request_size) + 7) & ~32'd7;
                if (size >= PB - 2 * HB) begin
                    r.status = ST_TOOBIG;
                end else begin
                    need = size + HB;
                    done = 1'b0;
                    body = 0;
                    for (int unsigned p = 0; p < pages_open_mdl && p < PageMax && !done; p++) begin
                        merge_page(p * PB);
                        done = fit_page(p * PB, need, body);
                    end
                    if (done) begin
                        r.value = body[15:0];
                    end else if (pages_open_mdl < PageMax) begin
                        hdr_set(pages_open_mdl * PB, need, 1'b1);
                        hdr_set(pages_open_mdl * PB + need, PB - need, 1'b0);
                        r.value = 16'(pages_open_mdl * PB + HB);
                        pages_open_mdl++;
                    end else begin
                        r.status = ST_NOSPACE;
                    end
                end
            end
            OP_FREE, OP_QUERY: begin
                pg = w.address / PB;
                off = w.address - pg * PB;
                if (pg >= pages_open_mdl || off < HB) begin
                    r.status = ST_BADADDR;
                end else begin
                    s = hdr_size(w.address - HB);
                    if (t_op'(w.operation) == OP_FREE) hdr_set(w.address - HB, s, 1'b0);
                    else r.value = (s >= HB) ? 16'(s - HB) : 16'd0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // send one word, predict it on acceptance
    task automatic send_word(t_op op, int unsigned req, int unsigned addr,
                             output t_out_word pred);
        t_in_word w;
        w.operation = op;
        w.request_size = req[15:0];
        w.address = addr[15:0];
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = predict_heap(w);
        expected_words.push_back(pred);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // field extremes, bad addresses, unused code, merging of free runs
    task automatic test_directed_limits();
        t_out_word p;
        int unsigned a;
        int unsigned b;
        send_word(OP_QUERY, 0, 16'd8, p);          // no page open yet
        send_word(OP_ALLOC, 0, 0, p);
        a = p.value;
        send_word(OP_ALLOC, 1, 16'hFFFF, p);
        b = p.value;
        send_word(OP_ALLOC, 4079, 0, p);           // rounds to too large
        send_word(OP_ALLOC, 16'hFFFF, 16'hFFFF, p);
        send_word(OP_ALLOC, 40, 0, p);
        send_word(OP_QUERY, 0, a, p);
        send_word(OP_QUERY, 0, 4, p);              // header area
        send_word(OP_FREE, 0, 0, p);
        send_word(OP_QUERY, 0, 16'hFFFF, p);       // outside open pages
        send_word(OP_QUERY, 0, b + 3, p);          // slot not at a body
        send_word(OP_FREE, 16'hFFFF, b + 5, p);
        send_word(OP_NONE, 16'hFFFF, 16'hFFFF, p);
        send_word(OP_QUERY, 0, 16'd1000, p);       // size below the header
        send_word(OP_FREE, 0, a, p);
        send_word(OP_FREE, 0, b, p);
        send_word(OP_ALLOC, 16, 0, p);             // lands in the merged free run
        send_word(OP_ALLOC, 4071, 0, p);           // largest legal size
        send_word(OP_QUERY, 0, p.value, p);
        drain();
    endtask

    // open every page until no space is left
    task automatic test_fill_pages();
        t_out_word p;
        for (int i = 0; i < PageMax + 1; i++) begin
            send_word(OP_ALLOC, 4071, 0, p);
            if (p.status == ST_OK) live_bodies.push_back(p.value);
        end
        drain();
    endtask

    // mostly well-formed alloc/free/query mixes with some noise
    task automatic test_random(int n, int idle_pct, int stall_pct);
        t_out_word p;
        int unsigned k;
        int unsigned r;
        int unsigned sz;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (live_bodies.size() == 0 || r < 45) begin
                k = $urandom_range(99);
                if (k < 70) sz = $urandom_range(200);
                else if (k < 85) sz = $urandom_range(1024);
                else if (k < 95) sz = $urandom_range(4079);
                else sz = $urandom_range(16'hFFFF);
                send_word(OP_ALLOC, sz, $urandom_range(16'hFFFF), p);
                if (p.status == ST_OK) live_bodies.push_back(p.value);
            end else if (r < 80) begin
                k = $urandom_range(live_bodies.size() - 1);
                send_word(OP_FREE, $urandom_range(16'hFFFF), live_bodies[k], p);
                live_bodies.delete(k);
            end else if (r < 90) begin
                k = $urandom_range(live_bodies.size() - 1);
                send_word(OP_QUERY, $urandom_range(16'hFFFF), live_bodies[k], p);
            end else if (r < 95) begin
                send_word(t_op'($urandom_range(1) ? OP_FREE : OP_QUERY),
                          $urandom_range(16'hFFFF), $urandom_range(16'hFFFF), p);
            end else begin
                send_word(OP_NONE, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF), p);
            end
        end
        drain();
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checking
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                e = expected_words.pop_front();
                if (o_out_data.status !== e.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_out_data.status, e.status));
                if (o_out_data.value !== e.value)
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              o_out_data.value, e.value));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleMax) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < Span; i++) heap_hdr[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_limits();
        test_fill_pages();
        test_random(290, 0, 0);
        test_random(290, 53, 0);
        test_random(290, 0, 53);
        test_random(290, 36, 36);
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[first_fit_page_heap_allocator.f]
rtl/ffph_pkg.sv
rtl/ffph_mem.sv
rtl/first_fit_page_heap_allocator.sv
bench/tb.sv
